// File: rtl/core/slbwp_pkg.sv
// Package for the slice selector with starvation aging.
// Request/result structs, FSM state type, codes and register defaults.
// No dependencies.
package slbwp_pkg;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int USER_W     = 10;
    localparam int BB_LIMIT_W = 7;
    localparam int MT_LIMIT_W = 8;
    localparam int STEP_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BB_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MT_LIMIT = 1'd1;

    localparam logic [BB_LIMIT_W-1:0] BB_LIMIT_RESET = 7'd8;
    localparam logic [MT_LIMIT_W-1:0] MT_LIMIT_RESET = 8'd16;

    localparam logic ACT_CHOOSE = 1'b0;
    localparam logic ACT_CLEAR  = 1'b1;

    localparam logic [1:0] SLICE_LL = 2'd0;
    localparam logic [1:0] SLICE_BB = 2'd1;
    localparam logic [1:0] SLICE_MT = 2'd2;

    typedef struct packed {
        logic              action;
        logic [USER_W-1:0] user_index;
        logic              low_latency_pending;
        logic              broadband_pending;
        logic              machine_pending;
    } req_t;

    typedef struct packed {
        logic [1:0] chosen_slice;
        logic       was_forced;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_UPDATE
    } state_t;

endpackage

// File: rtl/core/slice_bwp_starvation_arbiter.sv
// Top level of the per-user slice selector with starvation aging.
// Depends on slbwp_pkg, slbwp_ctr_mem, slbwp_decide.
//
// Request channel: a request (req) is taken on a rising edge with start high
// and busy low. action CHOOSE picks a slice for req.user_index; action CLEAR
// zeroes that user's two wait counters and returns nothing.
// Result channel: done is high for one cycle with rsp valid; the receiver
// cannot hold it off, so nothing ever backs up into the block.
// Configuration: cfg_we writes cfg_data into register cfg_index (0: broadband
// limit, low 7 bits used; 1: machine-type limit) in the same edge, any time.
// Sequence: each request takes remainder steps when MAX_USERS is below 1024
// and user_index has to be wrapped (up to ten steps for MAX_USERS of 1), then
// the read, the registered read data and the write back. The result strobe
// comes the cycle after the write back, together with busy dropping.
// The block takes one request at a time.
// Reset: limits return to 8 and 16, then a clearing pass zeroes every entry
// of the counter memory, one entry a cycle, with busy high throughout.
module slice_bwp_starvation_arbiter
    import slbwp_pkg::*;
#(
    parameter int MAX_USERS    = 1024,
    parameter int COUNTER_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    output logic                 done,
    output rsp_t                 rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CW = COUNTER_BITS;
    localparam int WIDE_W = 17 + USER_W;

    function automatic int reduce_steps(input int m);
        int n;
        n = 0;
        for (int k = 0; k < USER_W; k++)
        begin
            if ((longint'(m) << k) < (longint'(1) << USER_W))
            begin
                n = n + 1;
            end
        end
        return n;
    endfunction

    localparam int NSTEP = reduce_steps(MAX_USERS);
    localparam logic [STEP_W-1:0] FIRST_STEP = STEP_W'((NSTEP > 0) ? NSTEP - 1 : 0);

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic [USER_W-1:0]     idx_reg, idx_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    req_t                  req_reg, req_next;
    logic [BB_LIMIT_W-1:0] bb_limit_reg, bb_limit_next;
    logic [MT_LIMIT_W-1:0] mt_limit_reg, mt_limit_next;
    logic                  done_reg, done_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  accept;
    logic                  clear_last;
    logic [WIDE_W-1:0]     sub_wide;
    logic                  sub_fits;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [2*CW-1:0]       mem_wdata;
    logic [2*CW-1:0]       mem_rdata;
    logic [CW-1:0]         bb_new;
    logic [CW-1:0]         mt_new;
    rsp_t                  dec_rsp;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign clear_last = (clr_reg == AW'(MAX_USERS - 1));
    assign sub_wide   = WIDE_W'(MAX_USERS) << step_reg;
    assign sub_fits   = WIDE_W'(idx_reg) >= sub_wide;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (NSTEP > 0) ? ST_REDUCE : ST_READ;
                end
            end
            ST_REDUCE:
            begin
                if (step_reg == '0)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        clr_next  = clr_reg;
        idx_next  = idx_reg;
        step_next = step_reg;
        req_next  = req_reg;
        done_next = 1'b0;
        rsp_next  = rsp_reg;
        mem_we    = 1'b0;
        mem_waddr = AW'(idx_reg);
        mem_wdata = {mt_new, bb_new};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next  = req;
                    idx_next  = req.user_index;
                    step_next = FIRST_STEP;
                end
            end
            ST_REDUCE:
            begin
                if (sub_fits)
                begin
                    idx_next = idx_reg - sub_wide[USER_W-1:0];
                end
                step_next = step_reg - STEP_W'(1);
            end
            ST_READ:
            begin
            end
            ST_UPDATE:
            begin
                mem_we    = 1'b1;
                done_next = (req_reg.action == ACT_CHOOSE);
                rsp_next  = dec_rsp;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        bb_limit_next = bb_limit_reg;
        mt_limit_next = mt_limit_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BB_LIMIT: bb_limit_next = cfg_data[BB_LIMIT_W-1:0];
                CFG_MT_LIMIT: mt_limit_next = cfg_data[MT_LIMIT_W-1:0];
                default:      bb_limit_next = bb_limit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            step_reg     <= '0;
            bb_limit_reg <= BB_LIMIT_RESET;
            mt_limit_reg <= MT_LIMIT_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            step_reg     <= step_next;
            bb_limit_reg <= bb_limit_next;
            mt_limit_reg <= mt_limit_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    slbwp_ctr_mem #(
        .DEPTH  (MAX_USERS),
        .AW     (AW),
        .DATA_W (2 * CW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (AW'(idx_reg)),
        .rdata (mem_rdata)
    );

    slbwp_decide #(
        .CW (CW)
    ) u_decide (
        .req      (req_reg),
        .bb_cnt   (mem_rdata[CW-1:0]),
        .mt_cnt   (mem_rdata[2*CW-1:CW]),
        .bb_limit (bb_limit_reg),
        .mt_limit (mt_limit_reg),
        .bb_next  (bb_new),
        .mt_next  (mt_new),
        .rsp      (dec_rsp)
    );

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// File: rtl/core/slbwp_ctr_mem.sv
// Per-user wait counter store: one write port, one read port, registered read.
// Depends on nothing.
module slbwp_ctr_mem #(
    parameter int DEPTH  = 1024,
    parameter int AW     = 10,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/slbwp_decide.sv
// Slice decision and counter update for one request.
// Depends on slbwp_pkg.
module slbwp_decide
    import slbwp_pkg::*;
#(
    parameter int CW = 8
) (
    input  req_t                  req,
    input  logic [CW-1:0]         bb_cnt,
    input  logic [CW-1:0]         mt_cnt,
    input  logic [BB_LIMIT_W-1:0] bb_limit,
    input  logic [MT_LIMIT_W-1:0] mt_limit,
    output logic [CW-1:0]         bb_next,
    output logic [CW-1:0]         mt_next,
    output rsp_t                  rsp
);

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
        sat_inc = (c == {CW{1'b1}}) ? c : c + CW'(1);
    endfunction

    logic bb_starved;
    logic mt_starved;

    assign bb_starved = req.broadband_pending && (bb_cnt >= CW'(bb_limit));
    assign mt_starved = req.machine_pending && (mt_cnt >= CW'(mt_limit));

    always_comb
    begin
        bb_next = bb_cnt;
        mt_next = mt_cnt;
        rsp.chosen_slice = SLICE_BB;
        rsp.was_forced = 1'b0;
        if (req.action == ACT_CLEAR)
        begin
            bb_next = '0;
            mt_next = '0;
        end
        else if (bb_starved)
        begin
            bb_next = '0;
            if (req.machine_pending)
            begin
                mt_next = sat_inc(mt_cnt);
            end
            rsp.was_forced = 1'b1;
        end
        else if (mt_starved)
        begin
            mt_next = '0;
            if (req.broadband_pending)
            begin
                bb_next = sat_inc(bb_cnt);
            end
            rsp.chosen_slice = SLICE_MT;
            rsp.was_forced = 1'b1;
        end
        else if (req.low_latency_pending)
        begin
            if (req.broadband_pending)
            begin
                bb_next = sat_inc(bb_cnt);
            end
            if (req.machine_pending)
            begin
                mt_next = sat_inc(mt_cnt);
            end
            rsp.chosen_slice = SLICE_LL;
        end
        else if (req.broadband_pending)
        begin
            bb_next = '0;
            if (req.machine_pending)
            begin
                mt_next = sat_inc(mt_cnt);
            end
        end
        else if (req.machine_pending)
        begin
            mt_next = '0;
            rsp.chosen_slice = SLICE_MT;
        end
    end

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for slice_bwp_starvation_arbiter: directed and random requests,
// an in-bench model of the per-user wait counters and limits, and in-order result checks.
// Depends on slbwp_pkg and the arbiter RTL.
module tb;
    import slbwp_pkg::*;

    localparam int USERS         = 1024;
    localparam int COUNTER_W     = 8;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam logic [COUNTER_W-1:0] WAIT_MAX = '1;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    req_t                  req       = '0;
    logic                  done;
    rsp_t                  rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BB_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    req_t pending_reqs[$];
    rsp_t expected_choices[$];

    bit [COUNTER_W-1:0]    bb_wait [USERS];
    bit [COUNTER_W-1:0]    mt_wait [USERS];
    logic [BB_LIMIT_W-1:0] bb_limit = BB_LIMIT_RESET;
    logic [MT_LIMIT_W-1:0] mt_limit = MT_LIMIT_RESET;

    logic [USER_W-1:0] hot_users [8];

    bit   req_taken    = 1'b0;
    bit   progress;
    rsp_t predicted;
    rsp_t got;
    int   idle_left    = 0;
    int   burst_left   = 0;
    int   stall_cycles = 0;
    int   mismatches   = 0;

    slice_bwp_starvation_arbiter #(
        .MAX_USERS    (USERS),
        .COUNTER_BITS (COUNTER_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [COUNTER_W-1:0] aged(input logic [COUNTER_W-1:0] c);
        return (c == WAIT_MAX) ? c : c + 1'b1;
    endfunction

    // Updates the wait counters for one request; returns 1 when a slice choice is due.
    function automatic bit predict_choice(input req_t r, output rsp_t choice);
        logic [COUNTER_W-1:0] bbw;
        logic [COUNTER_W-1:0] mtw;
        bbw = bb_wait[r.user_index];
        mtw = mt_wait[r.user_index];
        choice.chosen_slice = SLICE_BB;
        choice.was_forced   = 1'b0;
        if (r.action == ACT_CLEAR)
        begin
            bb_wait[r.user_index] = '0;
            mt_wait[r.user_index] = '0;
            return 1'b0;
        end
        if (r.broadband_pending && bbw >= bb_limit)
        begin
            bbw = '0;
            if (r.machine_pending)
                mtw = aged(mtw);
            choice.was_forced = 1'b1;
        end
        else if (r.machine_pending && mtw >= mt_limit)
        begin
            mtw = '0;
            if (r.broadband_pending)
                bbw = aged(bbw);
            choice.chosen_slice = SLICE_MT;
            choice.was_forced   = 1'b1;
        end
        else if (r.low_latency_pending)
        begin
            if (r.broadband_pending)
                bbw = aged(bbw);
            if (r.machine_pending)
                mtw = aged(mtw);
            choice.chosen_slice = SLICE_LL;
        end
        else if (r.broadband_pending)
        begin
            bbw = '0;
            if (r.machine_pending)
                mtw = aged(mtw);
        end
        else if (r.machine_pending)
        begin
            mtw = '0;
            choice.chosen_slice = SLICE_MT;
        end
        bb_wait[r.user_index] = bbw;
        mt_wait[r.user_index] = mtw;
        return 1'b1;
    endfunction

    task automatic push_req(input logic act, input logic [USER_W-1:0] user,
                            input logic ll, input logic bb, input logic mt);
        req_t r;
        r.action              = act;
        r.user_index          = user;
        r.low_latency_pending = ll;
        r.broadband_pending   = bb;
        r.machine_pending     = mt;
        pending_reqs.push_back(r);
    endtask

    // Mostly a few hot users so counters age; one in ten requests goes to any user.
    task automatic queue_random(input int count, input int hot, input int ll_pct,
                                input int bb_pct, input int mt_pct, input int clear_pct);
        req_t r;
        repeat (count)
        begin
            r.action = ($urandom_range(0, 99) < clear_pct) ? ACT_CLEAR : ACT_CHOOSE;
            if ($urandom_range(0, 9) == 0)
                r.user_index = USER_W'($urandom_range(0, USERS - 1));
            else
                r.user_index = hot_users[$urandom_range(0, hot - 1)];
            r.low_latency_pending = $urandom_range(0, 99) < ll_pct;
            r.broadband_pending   = $urandom_range(0, 99) < bb_pct;
            r.machine_pending     = $urandom_range(0, 99) < mt_pct;
            pending_reqs.push_back(r);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || start || expected_choices.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_limits(input logic [CFG_DATA_W-1:0] bb_data,
                              input logic [CFG_DATA_W-1:0] mt_data);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BB_LIMIT;
        cfg_data  <= bb_data;
        @(negedge clk);
        cfg_index <= CFG_MT_LIMIT;
        cfg_data  <= mt_data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Request driver: holds a request until taken, then idles a drawn number of cycles.
    always @(negedge clk)
    begin
        if (rst_n && !(start && !req_taken))
        begin
            if (req_taken)
            begin
                if (burst_left > 0)
                begin
                    burst_left--;
                    idle_left = 0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    burst_left = $urandom_range(10, 40);
                    idle_left  = 0;
                end
                else
                    idle_left = $urandom_range(0, 18);
            end
            if (idle_left == 0 && pending_reqs.size() != 0)
            begin
                req   <= pending_reqs.pop_front();
                start <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
                if (idle_left > 0)
                    idle_left--;
            end
        end
    end

    // Monitor: checks results, tracks limit writes, predicts taken requests.
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        progress  = 1'b0;
        if (rst_n)
        begin
            if (done)
            begin
                progress = 1'b1;
                got      = rsp;
                if (expected_choices.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result slice %0d forced %0b",
                                 $time, got.chosen_slice, got.was_forced);
                end
                else
                begin
                    predicted = expected_choices.pop_front();
                    if (got.chosen_slice !== predicted.chosen_slice ||
                        got.was_forced !== predicted.was_forced)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected slice %0d forced %0b, got slice %0d forced %0b",
                                     $time, predicted.chosen_slice, predicted.was_forced,
                                     got.chosen_slice, got.was_forced);
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_BB_LIMIT)
                    bb_limit = cfg_data[BB_LIMIT_W-1:0];
                else
                    mt_limit = cfg_data[MT_LIMIT_W-1:0];
            end
            if (start && !busy)
            begin
                req_taken = 1'b1;
                progress  = 1'b1;
                if (predict_choice(req, predicted))
                    expected_choices.push_back(predicted);
            end
            stall_cycles = progress ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            hot_users[i] = USER_W'($urandom_range(0, USERS - 1));
        hot_users[2] = '0;
        hot_users[3] = '1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset limits: every pending combination, then aging to both overrides
        for (int combo = 0; combo < 8; combo++)
            push_req(ACT_CHOOSE, '0, combo[2], combo[1], combo[0]);
        repeat (17) push_req(ACT_CHOOSE, '1, 1'b1, 1'b1, 1'b1);
        push_req(ACT_CLEAR, '1, 1'b1, 1'b1, 1'b1);
        push_req(ACT_CHOOSE, '1, 1'b1, 1'b1, 1'b1);

        set_limits(8'h80, 8'h00);
        queue_random(120, 4, 50, 50, 50, 5);
        set_limits(8'hFF, 8'hFF);
        queue_random(300, 2, 90, 90, 90, 0);
        // broadband forced whenever pending: machine-type counters run into saturation
        set_limits(8'h00, 8'hFF);
        queue_random(300, 2, 50, 90, 90, 0);
        set_limits(8'h01, 8'h01);
        queue_random(150, 8, 50, 50, 50, 5);
        set_limits(8'd100, 8'd200);
        queue_random(150, 4, 70, 60, 60, 3);
        repeat (2)
        begin
            set_limits(CFG_DATA_W'($urandom_range(0, 255)),
                       CFG_DATA_W'($urandom_range(1, 200)));
            queue_random(100, 8, 50, 50, 50, 5);
        end
        set_limits(CFG_DATA_W'(BB_LIMIT_RESET), MT_LIMIT_RESET);
        queue_random(100, 8, 40, 60, 60, 5);

        wait_drained();
        if (expected_choices.size() != 0)
            mismatches++;
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/slbwp_pkg.sv
rtl/core/slbwp_ctr_mem.sv
rtl/core/slbwp_decide.sv
rtl/core/slice_bwp_starvation_arbiter.sv
tb/sv/tb.sv
